[rtl/core/indexed_linked_list_engine_top_assert.svh]
// Assertion macros for the list engine.
// Each macro checks an implication on the rising edge of the given clock and
// is switched off while the given reset is high.
`ifndef INDEXED_LINKED_LIST_ENGINE_TOP_ASSERT_SVH
`define INDEXED_LINKED_LIST_ENGINE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ILLE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define ILLE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ILLE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ILLE_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/ille_pkg.sv]
// ----------------------------------------------------------------------------
// ille_pkg
// Shared field widths, request kinds and status codes of the list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ille_pkg;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 12;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  // Request kinds carried in tuser.
  typedef enum logic [KIND_W-1:0] {
    K_READ     = 3'd0,
    K_INS_HEAD = 3'd1,
    K_INS_TAIL = 3'd2,
    K_INS_POS  = 3'd3,
    K_DELETE   = 3'd4
  } kind_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_RANGE  = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  localparam logic [VAL_W-1:0] NO_VALUE = '1;

endpackage

`default_nettype wire

[rtl/core/ille_ram.sv]
// ----------------------------------------------------------------------------
// ille_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ille_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1026
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/indexed_linked_list_engine_top.sv]
// ----------------------------------------------------------------------------
// indexed_linked_list_engine_top
// Doubly linked list of values in a fixed node store with a free chain.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel: tuser holds the kind (read, insert at
//   head, insert at tail, insert before a position, delete at a position),
//   tdata the position and the value. Each request yields exactly one result
//   transfer on the m_ channel with the value read, a status and the count.
//   A request is taken only while the engine is idle; one request is worked
//   on at a time. The time taken is set by the link walk through the link
//   RAMs, one link per cycle from the nearer end of the list; out-of-range
//   requests, unused kinds and inserts at head or tail need no walk. After
//   reset the engine runs a clearing pass that links the sentinels and chains
//   the free entries; s_tready stays low during it. A finished result waits in
//   the output register while the receiver stalls; the next request can be
//   accepted meanwhile but its result is held until the output register is
//   free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_linked_list_engine_top_assert.svh"

module indexed_linked_list_engine_top #(
  parameter int NODE_CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // position[11:0], item_value[43:12], zero pad
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // read_value[31:0], status[33:32],
                                 // entry_count[44:34], zero pad
);

  import ille_pkg::*;

  localparam int DEPTH = NODE_CAPACITY + 2;
  localparam int NW    = $clog2(DEPTH);
  localparam int CW    = $clog2(NODE_CAPACITY + 1);
  localparam int PW    = (CW > POS_W) ? CW : POS_W;
  localparam logic [NW-1:0] HEAD_IDX   = '0;
  localparam logic [NW-1:0] TAIL_IDX   = NW'(1);
  localparam logic [NW-1:0] FIRST_FREE = NW'(2);
  localparam logic [NW-1:0] LAST_IDX   = NW'(DEPTH - 1);
  localparam logic [CW-1:0] CAP        = CW'(NODE_CAPACITY);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WALK, S_LINK, S_LINK_WAIT, S_FREE, S_FREE_WAIT,
    S_INS1, S_INS2, S_DEL1, S_DEL2, S_FINISH
  } state_t;

  state_t          state;
  logic [NW-1:0]   clr_idx;
  logic [NW-1:0]   free_head;
  logic [NW-1:0]   free_next;
  logic [CW-1:0]   cnt;
  kind_t           op_kind;
  logic [VAL_W-1:0] op_val;
  logic            ins_head;
  logic            walk_fwd;
  logic            walk_first;
  logic [NW-1:0]   walk_start;
  logic [CW-1:0]   walk_rem;
  logic [NW-1:0]   node;
  logic [NW-1:0]   nd_fwd;
  logic [NW-1:0]   nd_bwd;
  logic [VAL_W-1:0] res_val;
  status_t         res_status;

  // RAM ports.
  logic            fwd_we, bwd_we, val_we;
  logic [NW-1:0]   fwd_waddr, bwd_waddr, val_waddr, raddr;
  logic [NW-1:0]   fwd_wdata, bwd_wdata, fwd_rd, bwd_rd;
  logic [VAL_W-1:0] val_rd;

  // Request fields.
  logic [POS_W-1:0] in_pos;
  logic [VAL_W-1:0] in_val;
  kind_t            in_kind;
  logic [PW-1:0]    pos_x, cnt_x;
  logic             full;
  logic [NW-1:0]    walk_node;
  logic [NW-1:0]    clr_fwd;
  logic             take;

  assign in_pos  = s_tdata[POS_W-1:0];
  assign in_val  = s_tdata[POS_W+VAL_W-1:POS_W];
  assign in_kind = kind_t'(s_tuser);
  assign pos_x   = PW'(in_pos);
  assign cnt_x   = PW'(cnt);
  assign full    = (cnt >= CAP);
  assign s_tready = (state == S_IDLE);
  assign take    = s_tvalid && s_tready;
  assign walk_node = walk_fwd ? fwd_rd : bwd_rd;

  // Reset image of the forward links.
  always_comb begin
    if (clr_idx == HEAD_IDX) begin
      clr_fwd = TAIL_IDX;
    end else if (clr_idx == TAIL_IDX || clr_idx == LAST_IDX) begin
      clr_fwd = HEAD_IDX;
    end else begin
      clr_fwd = clr_idx + NW'(1);
    end
  end

  // RAM address and write control per state.
  always_comb begin
    fwd_we = 1'b0; bwd_we = 1'b0; val_we = 1'b0;
    fwd_waddr = node; fwd_wdata = free_head;
    bwd_waddr = node; bwd_wdata = nd_bwd;
    val_waddr = free_head;
    raddr = node;
    case (state)
      S_CLEAR: begin
        fwd_we = 1'b1; fwd_waddr = clr_idx; fwd_wdata = clr_fwd;
        bwd_we = 1'b1; bwd_waddr = clr_idx; bwd_wdata = HEAD_IDX;
      end
      S_WALK:  raddr = walk_first ? walk_start : walk_node;
      S_FREE:  raddr = free_head;
      S_INS1: begin
        fwd_we = 1'b1; fwd_waddr = free_head;
        fwd_wdata = ins_head ? nd_fwd : node;
        bwd_we = 1'b1; bwd_waddr = free_head;
        bwd_wdata = ins_head ? node : nd_bwd;
        val_we = 1'b1;
      end
      S_INS2: begin
        fwd_we = 1'b1; fwd_waddr = ins_head ? node : nd_bwd; fwd_wdata = free_head;
        bwd_we = 1'b1; bwd_waddr = ins_head ? nd_fwd : node; bwd_wdata = free_head;
      end
      S_DEL1: begin
        fwd_we = 1'b1; fwd_waddr = nd_bwd; fwd_wdata = nd_fwd;
        bwd_we = 1'b1; bwd_waddr = nd_fwd; bwd_wdata = nd_bwd;
      end
      S_DEL2: begin
        fwd_we = 1'b1; fwd_waddr = node; fwd_wdata = free_head;
      end
      default: ;
    endcase
  end

  ille_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_fwd_ram (
    .clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
    .raddr(raddr), .rdata(fwd_rd)
  );

  ille_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_bwd_ram (
    .clk(clk), .we(bwd_we), .waddr(bwd_waddr), .wdata(bwd_wdata),
    .raddr(raddr), .rdata(bwd_rd)
  );

  ille_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(op_val),
    .raddr(raddr), .rdata(val_rd)
  );

  // Sequencer with the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      free_head <= FIRST_FREE;
      cnt       <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // A new result loaded in the finish step takes the place of the old one.
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + NW'(1);
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            op_kind    <= in_kind;
            op_val     <= in_val;
            res_val    <= NO_VALUE;
            walk_first <= 1'b1;
            ins_head   <= (in_kind == K_INS_HEAD);
            if (pos_x < (cnt_x >> 1)) begin
              walk_fwd   <= 1'b1;
              walk_start <= HEAD_IDX;
              walk_rem   <= CW'(in_pos) + CW'(1);
            end else begin
              walk_fwd   <= 1'b0;
              walk_start <= TAIL_IDX;
              walk_rem   <= cnt - CW'(in_pos);
            end
            case (in_kind) inside
              K_READ, K_DELETE: begin
                if (pos_x < cnt_x) begin
                  res_status <= ST_DONE;
                  state      <= S_WALK;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= S_FINISH;
                end
              end
              K_INS_HEAD, K_INS_TAIL: begin
                if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_FINISH;
                end else begin
                  res_status <= ST_DONE;
                  node       <= (in_kind == K_INS_HEAD) ? HEAD_IDX : TAIL_IDX;
                  state      <= S_LINK;
                end
              end
              K_INS_POS: begin
                if (pos_x > cnt_x) begin
                  res_status <= ST_RANGE;
                  state      <= S_FINISH;
                end else if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_FINISH;
                end else if (pos_x == cnt_x) begin
                  res_status <= ST_DONE;
                  node       <= TAIL_IDX;
                  state      <= S_LINK;
                end else begin
                  res_status <= ST_DONE;
                  state      <= S_WALK;
                end
              end
              default: begin
                res_status <= ST_DONE;
                state      <= S_FINISH;
              end
            endcase
          end
        end
        // One link per cycle; the RAM output addresses the next read.
        S_WALK: begin
          walk_first <= 1'b0;
          if (!walk_first) begin
            walk_rem <= walk_rem - CW'(1);
            if (walk_rem == CW'(1)) begin
              node  <= walk_node;
              state <= S_LINK;
            end
          end
        end
        S_LINK: state <= S_LINK_WAIT;
        S_LINK_WAIT: begin
          nd_fwd <= fwd_rd;
          nd_bwd <= bwd_rd;
          case (op_kind)
            K_READ: begin
              res_val <= val_rd;
              state   <= S_FINISH;
            end
            K_DELETE: state <= S_DEL1;
            default:  state <= S_FREE;
          endcase
        end
        S_FREE:      state <= S_FREE_WAIT;
        S_FREE_WAIT: begin
          free_next <= fwd_rd;
          state     <= S_INS1;
        end
        S_INS1: state <= S_INS2;
        S_INS2: begin
          free_head <= free_next;
          cnt       <= cnt + CW'(1);
          state     <= S_FINISH;
        end
        S_DEL1: state <= S_DEL2;
        S_DEL2: begin
          free_head <= node;
          cnt       <= cnt - CW'(1);
          state     <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, COUNT_W'(cnt), res_status, res_val};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The list never holds more values than the store has room for.
  `ILLE_ASSERT_IMP(a_cnt_cap, clk, rst, 1'b1, cnt <= CAP, "list count above capacity")
  // With room left, the free chain starts at a non-sentinel entry.
  `ILLE_ASSERT_IMP(a_free_ok, clk, rst, (state == S_IDLE) && (cnt < CAP),
    free_head >= FIRST_FREE, "free chain head on a sentinel")
  // The count moves only in the link update steps.
  `ILLE_ASSERT_NXT(a_cnt_hold, clk, rst, (state != S_INS2) && (state != S_DEL2),
    $stable(cnt), "list count changed outside a link update")

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed linked list engine. A driver sends
// requests from a queue of pending transfers, and a predictor keeps its own
// copy of the list and works out each expected result. A monitor compares
// every result transfer, field by field, with the oldest expected result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import ille_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 1024;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] position;
    logic [31:0] item_value;
  } request_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [10:0] entry_count;
  } result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;

  indexed_linked_list_engine_top #(.NODE_CAPACITY(CAP)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  request_t   pending_requests[$];
  result_t    expected_results[$];
  logic [31:0] list_values[$];
  int         error_count = 0;
  int         results_seen = 0;
  int         full_drops = 0;
  int         range_hits = 0;
  bit         quiet_phase = 1'b0;
  bit         stimulus_done = 1'b0;

  // List predictor: a plain ordered array of values stands in for the store.
  function automatic result_t predict_list_op(request_t req);
    result_t r;
    int cnt;
    cnt = list_values.size();
    r.read_value = NO_VALUE;
    r.status = ST_DONE;
    case (req.kind)
      K_READ: begin
        if (req.position < cnt) r.read_value = list_values[req.position];
        else r.status = ST_RANGE;
      end
      K_INS_HEAD: begin
        if (cnt >= CAP) r.status = ST_FULL;
        else list_values.push_front(req.item_value);
      end
      K_INS_TAIL: begin
        if (cnt >= CAP) r.status = ST_FULL;
        else list_values.push_back(req.item_value);
      end
      K_INS_POS: begin
        if (req.position > cnt) r.status = ST_RANGE;
        else if (cnt >= CAP) r.status = ST_FULL;
        else list_values.insert(req.position, req.item_value);
      end
      K_DELETE: begin
        if (req.position < cnt) list_values.delete(req.position);
        else r.status = ST_RANGE;
      end
      default: ;
    endcase
    r.entry_count = 11'(list_values.size());
    return r;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random idling unless in the quiet stretch.
  function automatic bit idle_now();
    return !quiet_phase && ($urandom_range(99) < 34);
  endfunction

  // Driver: presents the next pending request; a separate block predicts it on transfer.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if ((!s_tvalid || s_tready) ) begin
        if (pending_requests.size() > 0 && !idle_now()) begin
          request_t req;
          req = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= req.kind;
          s_tdata  <= {4'd0, req.item_value, req.position};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Predict at the transfer edge from the values being accepted.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      request_t req;
      result_t r;
      req.kind = s_tuser;
      req.position = s_tdata[11:0];
      req.item_value = s_tdata[43:12];
      r = predict_list_op(req);
      if (r.status == ST_FULL) full_drops++;
      if (r.status == ST_RANGE) range_hits++;
      expected_results.push_back(r);
    end
  end

  // Receiver stalls.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !idle_now();
  end

  // Monitor: compares each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      result_t got;
      result_t exp_r;
      got.read_value = m_tdata[31:0];
      got.status = m_tdata[33:32];
      got.entry_count = m_tdata[44:34];
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer %h", m_tdata);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.read_value !== exp_r.read_value) begin
          $error("read_value expected %h actual %h", exp_r.read_value, got.read_value);
          error_count++;
        end
        if (got.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, got.status);
          error_count++;
        end
        if (got.entry_count !== exp_r.entry_count) begin
          $error("entry_count expected %0d actual %0d", exp_r.entry_count,
                 got.entry_count);
          error_count++;
        end
        if (m_tdata[47:45] !== 3'd0) begin
          $error("pad expected 0 actual %b", m_tdata[47:45]);
          error_count++;
        end
      end
    end
  end

  function automatic request_t make_request(logic [2:0] k, logic [11:0] p, logic [31:0] v);
    request_t req;
    req.kind = k;
    req.position = p;
    req.item_value = v;
    return req;
  endfunction

  // Random request with a position mostly near the current span of the list.
  function automatic request_t random_request(int approx_count);
    request_t req;
    int pick;
    pick = $urandom_range(99);
    req.item_value = $urandom;
    if (pick < 20) req.kind = K_READ;
    else if (pick < 35) req.kind = K_INS_HEAD;
    else if (pick < 50) req.kind = K_INS_TAIL;
    else if (pick < 70) req.kind = K_INS_POS;
    else if (pick < 95) req.kind = K_DELETE;
    else req.kind = 3'($urandom_range(7));
    if ($urandom_range(19) == 0) req.position = 12'($urandom);
    else req.position = 12'($urandom_range(approx_count + 1));
    return req;
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    int i;
    int cnt_now;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list cases, extremes, every kind, unused kinds.
    pending_requests.push_back(make_request(K_READ, 12'd0, 32'd0));
    pending_requests.push_back(make_request(K_DELETE, 12'd0, 32'd0));
    pending_requests.push_back(make_request(K_INS_POS, 12'd1, 32'd5));
    pending_requests.push_back(make_request(K_INS_POS, 12'd0, 32'h8000_0000));
    pending_requests.push_back(make_request(K_INS_HEAD, 12'hFFF, 32'h7FFF_FFFF));
    pending_requests.push_back(make_request(K_INS_TAIL, 12'hFFF, 32'hFFFF_FFFF));
    pending_requests.push_back(make_request(K_INS_POS, 12'd3, 32'h0000_0000));
    pending_requests.push_back(make_request(K_INS_POS, 12'd1, 32'h5A5A_A5A5));
    pending_requests.push_back(make_request(K_READ, 12'd0, 32'hFFFF_FFFF));
    pending_requests.push_back(make_request(K_READ, 12'd4, 32'd0));
    pending_requests.push_back(make_request(K_READ, 12'd5, 32'd0));
    pending_requests.push_back(make_request(K_READ, 12'hFFF, 32'd0));
    pending_requests.push_back(make_request(3'd5, 12'hFFF, 32'hFFFF_FFFF));
    pending_requests.push_back(make_request(3'd6, 12'd0, 32'd0));
    pending_requests.push_back(make_request(3'd7, 12'h555, 32'h1234_5678));
    pending_requests.push_back(make_request(K_DELETE, 12'd2, 32'd0));
    pending_requests.push_back(make_request(K_DELETE, 12'd4, 32'd0));
    pending_requests.push_back(make_request(K_DELETE, 12'd0, 32'd0));
    pending_requests.push_back(make_request(K_READ, 12'd2, 32'd0));
    wait_drained();

    // Random phase with a quiet stretch in the middle.
    for (i = 0; i < 600; i++) begin
      if (i == 200) begin
        wait_drained();
        quiet_phase = 1'b1;
      end
      if (i == 300) begin
        wait_drained();
        quiet_phase = 1'b0;
      end
      if (pending_requests.size() > 4) wait (pending_requests.size() <= 4);
      pending_requests.push_back(random_request(list_values.size()));
      @(posedge clk);
    end
    wait_drained();

    // Positions right at and around the current end of the list.
    cnt_now = list_values.size();
    pending_requests.push_back(make_request(K_READ, 12'(cnt_now - 1), 32'd0));
    pending_requests.push_back(make_request(K_READ, 12'(cnt_now), 32'd0));
    pending_requests.push_back(make_request(K_READ, 12'(cnt_now / 2), 32'd0));
    pending_requests.push_back(make_request(K_INS_POS, 12'(cnt_now), 32'd4));
    pending_requests.push_back(make_request(K_INS_POS, 12'(cnt_now + 2), 32'd5));
    pending_requests.push_back(make_request(K_DELETE, 12'(cnt_now + 1), 32'd0));
    pending_requests.push_back(make_request(K_DELETE, 12'(cnt_now), 32'd0));
    pending_requests.push_back(make_request(K_INS_POS, 12'(cnt_now / 2), 32'd6));
    pending_requests.push_back(make_request(K_READ, 12'd0, 32'd0));
    for (i = 0; i < 60; i++)
      pending_requests.push_back(random_request(cnt_now));
    wait_drained();
    stimulus_done = 1'b1;

    repeat (600) @(posedge clk);
    $display("Covered %0d results, %0d full-store drops, %0d out-of-range requests.",
             results_seen, full_drops, range_hits);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Global watchdog.
  initial begin
    #60ms;
    $display("tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/ille_pkg.sv
rtl/core/ille_ram.sv
rtl/core/indexed_linked_list_engine_top.sv
bench/tb.sv
